// ===== rtl/core/cached_inner_product_mod2_mod3_macros.svh =====
// Assertion macros shared by the checker of the cached inner product block.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef CACHED_INNER_PRODUCT_MOD2_MOD3_MACROS_SVH
`define CACHED_INNER_PRODUCT_MOD2_MOD3_MACROS_SVH

// A condition in one cycle implies a consequence in the next, outside reset.
`define CIPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after reset is seen.
`define CIPM_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/cipm_pkg.sv =====
// Package of the cached inner product block: sizes, codes and the queue entry type.
// Depends on nothing; the top level, front, queue, back and testbench import it.
`default_nettype none

package cipm_pkg;

  // Sizes of the key cache.
  localparam int CACHE_INDEX_BITS = 8;
  localparam int BLOCK_COUNT      = 16;
  localparam int RING_WIDTH       = 128;
  localparam int WORD_BITS        = 64;
  localparam int HALVES           = 2;

  localparam int BLOCK_BITS  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int ADDR_BITS   = BLOCK_BITS + CACHE_INDEX_BITS;
  localparam int TABLE_DEPTH = 2 ** ADDR_BITS;

  // Lanes at or above the ring width read as zero on the result.
  localparam logic [WORD_BITS-1:0] LOW_LANE_MASK =
      (RING_WIDTH >= 64) ? {WORD_BITS{1'b1}} : ((64'd1 << RING_WIDTH) - 64'd1);
  localparam logic [WORD_BITS-1:0] HIGH_LANE_MASK =
      (RING_WIDTH >= 128) ? {WORD_BITS{1'b1}} :
      (RING_WIDTH <= 64)  ? {WORD_BITS{1'b0}} :
      ((64'd1 << (RING_WIDTH - 64)) - 64'd1);

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_INDEX = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    TABLE_MOD2    = 2'd0,
    TABLE_MOD3_HI = 2'd1,
    TABLE_MOD3_LO = 2'd2
  } table_sel_t;

  // One classified operation as it travels through the queue.
  typedef struct packed {
    logic                   is_index;
    logic                   last;
    table_sel_t             target;
    logic [ADDR_BITS-1:0]   addr;
    logic                   half;
    logic [WORD_BITS-1:0]   word;
  } cipm_op_t;

endpackage

`default_nettype wire

// ===== rtl/core/cipm_if.sv =====
// Channel interfaces of the cached inner product block: input items and results.
// Depends on nothing but the handshake convention valid/ready.
`default_nettype none

interface cipm_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  table_select;
  logic [3:0]  block_number;
  logic [7:0]  entry_number;
  logic        half_select;
  logic [63:0] table_word;
  logic [7:0]  input_index;

  modport source (output valid, kind, table_select, block_number, entry_number,
                  half_select, table_word, input_index, input ready);
  modport sink (input valid, kind, table_select, block_number, entry_number,
                half_select, table_word, input_index, output ready);
endinterface

interface cipm_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] sum2_low;
  logic [63:0] sum2_high;
  logic [63:0] sum3_hi_plane_low;
  logic [63:0] sum3_hi_plane_high;
  logic [63:0] sum3_lo_plane_low;
  logic [63:0] sum3_lo_plane_high;

  modport source (output valid, sum2_low, sum2_high, sum3_hi_plane_low,
                  sum3_hi_plane_high, sum3_lo_plane_low, sum3_lo_plane_high,
                  input ready);
  modport sink (input valid, sum2_low, sum2_high, sum3_hi_plane_low,
                sum3_hi_plane_high, sum3_lo_plane_low, sum3_lo_plane_high,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cached_inner_product_mod2_mod3.sv =====
// Top level of the cached inner product block: front, queue and back joined.
// Depends on cipm_pkg, cipm_if, cipm_front, cipm_queue and cipm_back.
//
//   channel  | direction | beat carries
//   ---------+-----------+-----------------------------------------------
//   item     | in        | one table load (half an entry) or one cache index
//   result   | out       | mod-2 sum and both mod-3 planes, 128 bits each
//
// One beat per cycle is accepted while the queue has room, loads and indices alike.
// A vector's sum is shown after its last index passes the queue and the table read.
// Reset clears the queue, block position, accumulators and result register; the
// tables are not cleared and read as undefined until written.
// Input ready falls only when the two-entry queue is full; the back holds only when
// a finished sum meets a result register that has not been taken.
`default_nettype none

module cached_inner_product_mod2_mod3
  import cipm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  cipm_item_if.sink     item,
  cipm_result_if.source result
);

  logic     push;
  cipm_op_t push_op;
  logic     full;
  logic     pop;
  cipm_op_t pop_op;
  logic     nonempty;

  cipm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .full    (full),
    .push    (push),
    .push_op (push_op)
  );

  cipm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_op  (push_op),
    .full     (full),
    .pop      (pop),
    .pop_op   (pop_op),
    .nonempty (nonempty)
  );

  cipm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .op       (pop_op),
    .pop      (pop),
    .result   (result)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cipm_queue.sv =====
// Short queue of classified operations between the front and the back.
// Depends on cipm_pkg for the entry type and the depth.
`default_nettype none

module cipm_queue
  import cipm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire cipm_op_t push_op,
  output logic          full,
  input  wire logic     pop,
  output cipm_op_t      pop_op,
  output logic          nonempty
);

  cipm_op_t               entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCOUNT_BITS-1:0] count;
  logic [QCOUNT_BITS-1:0] count_next;
  logic                   do_push;
  logic                   do_pop;

  assign full     = (count == QCOUNT_BITS'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_op   = entries[rd_ptr];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + QCOUNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - QCOUNT_BITS'(1);
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cipm_front.sv =====
// Front of the cached inner product block: takes input beats, drops loads that
// hit no table, tracks the block position and forms table addresses. Uses cipm_pkg.
`default_nettype none

module cipm_front
  import cipm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  cipm_item_if.sink item,
  input  wire logic full,
  output logic      push,
  output cipm_op_t  push_op
);

  logic [BLOCK_BITS-1:0]       position;
  logic                        accept;
  logic                        is_index;
  logic                        load_hits;
  logic                        last_block;
  logic [CACHE_INDEX_BITS-1:0] entry_low;
  logic [CACHE_INDEX_BITS-1:0] index_low;

  assign item.ready = !full;
  assign accept     = item.valid && !full;
  assign is_index   = (item.kind == KIND_INDEX);

  // A load is kept only for a known table and a block that exists.
  assign load_hits = (item.table_select == TABLE_MOD2 ||
                      item.table_select == TABLE_MOD3_HI ||
                      item.table_select == TABLE_MOD3_LO) &&
                     (32'(item.block_number) < BLOCK_COUNT);

  assign last_block = (position == BLOCK_BITS'(BLOCK_COUNT - 1));
  assign entry_low  = CACHE_INDEX_BITS'(item.entry_number);
  assign index_low  = CACHE_INDEX_BITS'(item.input_index);

  // Classify the beat and build the queue entry.
  always_comb begin
    push            = accept && (is_index || load_hits);
    push_op.is_index = is_index;
    push_op.last     = last_block;
    push_op.target   = table_sel_t'(item.table_select);
    push_op.half     = item.half_select;
    push_op.word     = item.table_word;
    if (is_index) begin
      push_op.addr = {position, index_low};
    end else begin
      push_op.addr = {BLOCK_BITS'(item.block_number), entry_low};
    end
  end

  // Block position steps once per accepted index and wraps after the last block.
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept && is_index) begin
      position <= last_block ? '0 : position + BLOCK_BITS'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cipm_back.sv =====
// Back of the cached inner product block: the three key-cache tables, the table
// read stage, the mod-2 and mod-3 accumulators and the result register. Uses cipm_pkg.
`default_nettype none

module cipm_back
  import cipm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     nonempty,
  input  wire cipm_op_t op,
  output logic          pop,
  cipm_result_if.source result
);

  logic                 rd_valid;
  logic                 rd_last;
  logic [WORD_BITS-1:0] rd_mod2 [HALVES];
  logic [WORD_BITS-1:0] rd_hi   [HALVES];
  logic [WORD_BITS-1:0] rd_lo   [HALVES];

  logic [WORD_BITS-1:0] acc2  [HALVES];
  logic [WORD_BITS-1:0] acc_hi [HALVES];
  logic [WORD_BITS-1:0] acc_lo [HALVES];
  logic [WORD_BITS-1:0] acc2_next  [HALVES];
  logic [WORD_BITS-1:0] acc_hi_next [HALVES];
  logic [WORD_BITS-1:0] acc_lo_next [HALVES];

  logic                 out_valid;
  logic [WORD_BITS-1:0] out2  [HALVES];
  logic [WORD_BITS-1:0] out_hi [HALVES];
  logic [WORD_BITS-1:0] out_lo [HALVES];

  logic                 stall;
  logic                 do_read;
  logic                 finish;

  // A finished sum waits while the result register is still held.
  assign stall   = rd_valid && rd_last && out_valid && !result.ready;
  assign pop     = nonempty && !stall;
  assign do_read = pop && op.is_index;
  assign finish  = rd_valid && rd_last && !stall;

  // One bank per half for each table; a load writes one half of one entry.
  for (genvar h = 0; h < HALVES; h++) begin : g_half
    logic [WORD_BITS-1:0] mod2_mem  [TABLE_DEPTH];
    logic [WORD_BITS-1:0] mod3h_mem [TABLE_DEPTH];
    logic [WORD_BITS-1:0] mod3l_mem [TABLE_DEPTH];
    logic                 wr_half;

    assign wr_half = pop && !op.is_index && (op.half == 1'(h));

    always_ff @(posedge clk) begin
      if (wr_half && op.target == TABLE_MOD2) begin
        mod2_mem[op.addr] <= op.word;
      end
      if (wr_half && op.target == TABLE_MOD3_HI) begin
        mod3h_mem[op.addr] <= op.word;
      end
      if (wr_half && op.target == TABLE_MOD3_LO) begin
        mod3l_mem[op.addr] <= op.word;
      end
    end

    // Registered read for an index, held while the accumulate stage stalls.
    always_ff @(posedge clk) begin
      if (do_read) begin
        rd_mod2[h] <= mod2_mem[op.addr];
        rd_hi[h]   <= mod3h_mem[op.addr];
        rd_lo[h]   <= mod3l_mem[op.addr];
      end
    end
  end

  // Read stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (!stall) begin
      rd_valid <= do_read;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      rd_last <= op.last;
    end
  end

  // XOR for mod 2 and lane-wise bit-sliced addition for mod 3.
  always_comb begin
    for (int h = 0; h < HALVES; h++) begin
      acc2_next[h]   = acc2[h] ^ rd_mod2[h];
      acc_hi_next[h] = (acc_lo[h] ^ rd_hi[h]) & (acc_hi[h] ^ rd_lo[h]);
      acc_lo_next[h] = (acc_lo[h] ^ rd_lo[h]) | (acc_hi[h] ^ rd_lo[h] ^ rd_hi[h]);
    end
  end

  // Accumulators clear after the last block of a vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int h = 0; h < HALVES; h++) begin
        acc2[h]   <= '0;
        acc_hi[h] <= '0;
        acc_lo[h] <= '0;
      end
    end else if (rd_valid && !stall) begin
      for (int h = 0; h < HALVES; h++) begin
        acc2[h]   <= rd_last ? '0 : acc2_next[h];
        acc_hi[h] <= rd_last ? '0 : acc_hi_next[h];
        acc_lo[h] <= rd_last ? '0 : acc_lo_next[h];
      end
    end
  end

  // Result register, masked to the ring width.
  always_ff @(posedge clk) begin
    if (finish) begin
      out2[0]   <= acc2_next[0] & LOW_LANE_MASK;
      out2[1]   <= acc2_next[1] & HIGH_LANE_MASK;
      out_hi[0] <= acc_hi_next[0] & LOW_LANE_MASK;
      out_hi[1] <= acc_hi_next[1] & HIGH_LANE_MASK;
      out_lo[0] <= acc_lo_next[0] & LOW_LANE_MASK;
      out_lo[1] <= acc_lo_next[1] & HIGH_LANE_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid              = out_valid;
  assign result.sum2_low           = out2[0];
  assign result.sum2_high          = out2[1];
  assign result.sum3_hi_plane_low  = out_hi[0];
  assign result.sum3_hi_plane_high = out_hi[1];
  assign result.sum3_lo_plane_low  = out_lo[0];
  assign result.sum3_lo_plane_high = out_lo[1];

endmodule

`default_nettype wire

// ===== rtl/core/cipm_checker.sv =====
// Port-level checker of the cached inner product block and its bind to the top level.
// Depends on the assertion macros header.
`default_nettype none

`include "cached_inner_product_mod2_mod3_macros.svh"

module cipm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_ready,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [63:0] sum2_low,
  input wire logic [63:0] sum2_high,
  input wire logic [63:0] sum3_hi_plane_low,
  input wire logic [63:0] sum3_hi_plane_high,
  input wire logic [63:0] sum3_lo_plane_low,
  input wire logic [63:0] sum3_lo_plane_high
);

  // A result beat that is not taken stays offered.
  `CIPM_ASSERT_NEXT(a_result_held, clk, rst, result_valid && !result_ready, result_valid, "result valid dropped while stalled")

  // A stalled result keeps its sums.
  `CIPM_ASSERT_NEXT(a_result_stable, clk, rst, result_valid && !result_ready, $stable(sum2_low) && $stable(sum2_high) && $stable(sum3_hi_plane_low) && $stable(sum3_hi_plane_high) && $stable(sum3_lo_plane_low) && $stable(sum3_lo_plane_high), "result changed while stalled")

  // Reset empties the result register.
  `CIPM_ASSERT_AFTER_RESET(a_reset_no_result, clk, rst, !result_valid, "result offered after reset")

  // Reset empties the queue, so input is taken at once.
  `CIPM_ASSERT_AFTER_RESET(a_reset_ready, clk, rst, item_ready, "input not ready after reset")

endmodule

bind cached_inner_product_mod2_mod3 cipm_checker u_cipm_checker (
  .clk                (clk),
  .rst                (rst),
  .item_ready         (item.ready),
  .result_valid       (result.valid),
  .result_ready       (result.ready),
  .sum2_low           (result.sum2_low),
  .sum2_high          (result.sum2_high),
  .sum3_hi_plane_low  (result.sum3_hi_plane_low),
  .sum3_hi_plane_high (result.sum3_hi_plane_high),
  .sum3_lo_plane_low  (result.sum3_lo_plane_low),
  .sum3_lo_plane_high (result.sum3_lo_plane_high)
);

`default_nettype wire

// ===== bench/cipm_checker.sv =====
`timescale 1ns / 100ps
// Checker for the cached inner product block: it watches the item and result channels.
// It keeps its own copy of the three key-cache tables and of the running sums.
// Depends on cipm_pkg and the channel interfaces in cipm_if.

module cipm_scoreboard
  import cipm_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  cipm_item_if   item,
  cipm_result_if result,
  output int     errors,
  output int     pending
);

  localparam int ENTRIES = 2 ** CACHE_INDEX_BITS;

  // One finished vector: the mod-2 sum and both mod-3 planes, low half first.
  typedef struct packed {
    logic [63:0] sum2_low;
    logic [63:0] sum2_high;
    logic [63:0] hi_plane_low;
    logic [63:0] hi_plane_high;
    logic [63:0] lo_plane_low;
    logic [63:0] lo_plane_high;
  } inner_sums_t;

  // Shadow copies of the tables, indexed by block and entry, then by half.
  logic [63:0] par_words     [0:TABLE_DEPTH-1][0:HALVES-1];
  logic [63:0] trit_hi_words [0:TABLE_DEPTH-1][0:HALVES-1];
  logic [63:0] trit_lo_words [0:TABLE_DEPTH-1][0:HALVES-1];

  // Running sums of the vector in progress.
  logic [63:0] par_sum     [0:HALVES-1];
  logic [63:0] trit_hi_sum [0:HALVES-1];
  logic [63:0] trit_lo_sum [0:HALVES-1];
  int          blocks_taken;

  inner_sums_t sums_due[$];

  initial errors = 0;

  function automatic void clear_sums();
    for (int h = 0; h < HALVES; h++) begin
      par_sum[h]     = '0;
      trit_hi_sum[h] = '0;
      trit_lo_sum[h] = '0;
    end
    blocks_taken = 0;
  endfunction

  // A load beat writes one half of one entry; an unknown table or block is dropped.
  function automatic void store_word();
    int slot;
    slot = int'(item.block_number) * ENTRIES + int'(item.entry_number) % ENTRIES;
    if (int'(item.block_number) < BLOCK_COUNT) begin
      if (item.table_select == TABLE_MOD2)
        par_words[slot][item.half_select] = item.table_word;
      else if (item.table_select == TABLE_MOD3_HI)
        trit_hi_words[slot][item.half_select] = item.table_word;
      else if (item.table_select == TABLE_MOD3_LO)
        trit_lo_words[slot][item.half_select] = item.table_word;
    end
  endfunction

  // An index beat folds one entry of the current block into the sums.
  // The mod-3 planes are added lane by lane with digits coded 0=(0,0), 1=(0,1), 2=(1,1).
  function automatic void fold_index();
    int          slot;
    logic [63:0] acc_hi, acc_lo, add_hi, add_lo;
    inner_sums_t done;
    slot = blocks_taken * ENTRIES + int'(item.input_index) % ENTRIES;
    for (int h = 0; h < HALVES; h++) begin
      acc_hi = trit_hi_sum[h];
      acc_lo = trit_lo_sum[h];
      add_hi = trit_hi_words[slot][h];
      add_lo = trit_lo_words[slot][h];
      par_sum[h]     = par_sum[h] ^ par_words[slot][h];
      trit_hi_sum[h] = (acc_lo ^ add_hi) & (acc_hi ^ add_lo);
      trit_lo_sum[h] = (acc_lo ^ add_lo) | (acc_hi ^ add_lo ^ add_hi);
    end
    blocks_taken++;
    if (blocks_taken == BLOCK_COUNT) begin
      done.sum2_low      = par_sum[0] & LOW_LANE_MASK;
      done.sum2_high     = par_sum[1] & HIGH_LANE_MASK;
      done.hi_plane_low  = trit_hi_sum[0] & LOW_LANE_MASK;
      done.hi_plane_high = trit_hi_sum[1] & HIGH_LANE_MASK;
      done.lo_plane_low  = trit_lo_sum[0] & LOW_LANE_MASK;
      done.lo_plane_high = trit_lo_sum[1] & HIGH_LANE_MASK;
      sums_due.push_back(done);
      clear_sums();
    end
  endfunction

  function automatic void match_word(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", field, want, got);
      errors++;
    end
  endfunction

  // Each result beat is held against the oldest sum still owed.
  function automatic void check_sums();
    inner_sums_t want;
    if (sums_due.size() == 0) begin
      $error("result beat arrived with no sum outstanding");
      errors++;
    end else begin
      want = sums_due.pop_front();
      match_word("sum2_low", want.sum2_low, result.sum2_low);
      match_word("sum2_high", want.sum2_high, result.sum2_high);
      match_word("sum3_hi_plane_low", want.hi_plane_low, result.sum3_hi_plane_low);
      match_word("sum3_hi_plane_high", want.hi_plane_high, result.sum3_hi_plane_high);
      match_word("sum3_lo_plane_low", want.lo_plane_low, result.sum3_lo_plane_low);
      match_word("sum3_lo_plane_high", want.lo_plane_high, result.sum3_lo_plane_high);
    end
  endfunction

  // Both channels are sampled on the rising edge; the tables survive reset.
  always @(posedge clk) begin
    if (rst) begin
      clear_sums();
      sums_due.delete();
    end else begin
      if (result.valid && result.ready)
        check_sums();
      if (item.valid && item.ready) begin
        if (item.kind == KIND_INDEX)
          fold_index();
        else
          store_word();
      end
    end
    pending = sums_due.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Top of the testbench for the cached inner product block: clock, reset and stimulus.
// Depends on cipm_pkg, cipm_if, the block itself and cipm_scoreboard.

module tb;
  import cipm_pkg::*;

  localparam int          ENTRIES     = 2 ** CACHE_INDEX_BITS;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          ITEM_TARGET = 1300;
  localparam int          HOLD_AFTER  = 700;
  localparam int          HOLD_CYCLES = 400;
  localparam logic [1:0]  TABLE_NONE  = 2'd3;
  localparam logic [5:0]  ENTRY_FULL  = 6'h3f;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   cycles = 0;

  // Stimulus bookkeeping: which words of each entry hold data, and the block in turn.
  logic [5:0] loaded_mask [0:BLOCK_COUNT-1][0:ENTRIES-1];
  int         vec_pos     = 0;
  int         items_sent  = 0;
  int         calm_left   = 0;

  cipm_item_if   item_ch ();
  cipm_result_if result_ch ();

  cached_inner_product_mod2_mod3 dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  cipm_scoreboard checker_i (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Gaps between beats: mostly none or short, a few long, with calm stretches.
  function automatic int idle_cycles();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Offers one beat from the falling edge and holds it until a rising edge accepts it.
  task automatic push_item(input item_kind_t kind, input logic [1:0] sel,
                           input logic [3:0] blk, input logic [7:0] ent,
                           input logic half, input logic [63:0] word,
                           input logic [7:0] idx);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      @(negedge clk);
      item_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_ch.valid        = 1'b1;
    item_ch.kind         = kind;
    item_ch.table_select = sel;
    item_ch.block_number = blk;
    item_ch.entry_number = ent;
    item_ch.half_select  = half;
    item_ch.table_word   = word;
    item_ch.input_index  = idx;
    do @(posedge clk); while (!item_ch.ready);
    if (kind == KIND_INDEX) begin
      vec_pos = (vec_pos + 1) % BLOCK_COUNT;
      items_sent++;
    end else if (sel != TABLE_NONE && int'(blk) < BLOCK_COUNT) begin
      loaded_mask[blk][int'(ent) % ENTRIES][int'(sel) * 2 + int'(half)] = 1'b1;
      items_sent++;
    end
  endtask

  // Index beats carry random load fields, which the block must ignore.
  task automatic send_index(input int idx);
    push_item(KIND_INDEX, 2'($urandom_range(0, 3)), 4'($urandom), 8'($urandom),
              1'($urandom), rand_word(), 8'(idx));
  endtask

  task automatic send_load(input logic [1:0] sel, input int blk, input int ent,
                           input logic half, input logic [63:0] word);
    push_item(KIND_LOAD, sel, 4'(blk), 8'(ent), half, word, 8'($urandom));
  endtask

  // Picks an entry of the current block whose six words have all been written.
  function automatic int pick_index();
    int start, e;
    start = $urandom_range(0, ENTRIES - 1);
    for (int k = 0; k < ENTRIES; k++) begin
      e = (start + k) % ENTRIES;
      if (loaded_mask[vec_pos][e] == ENTRY_FULL) return e;
    end
    return 0;
  endfunction

  // Writes all six words of one entry in a shuffled order.
  task automatic fill_entry(input int blk, input int ent);
    int order [0:5];
    int j, t;
    for (int k = 0; k < 6; k++) order[k] = k;
    for (int k = 5; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < 6; k++)
      send_load(2'(order[k] / 2), blk, ent, 1'(order[k] % 2), rand_word());
  endtask

  // Result side: random back-pressure, and one long hold-off once the run is under way.
  initial begin
    int  r, run;
    bit  held_off;
    held_off = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      if (!held_off && items_sent >= HOLD_AFTER) begin
        held_off = 1'b1;
        @(negedge clk);
        result_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        @(negedge clk);
        if (r < 10) begin
          result_ch.ready = 1'b1;
          run = $urandom_range(30, 80);
        end else if (r < 70) begin
          result_ch.ready = 1'b1;
          run = $urandom_range(1, 12);
        end else if (r < 95) begin
          result_ch.ready = 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          result_ch.ready = 1'b0;
          run = $urandom_range(10, 40);
        end
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  // Item side: reset, table preload, a directed vector, random traffic, then the verdict.
  initial begin
    int r, blk, ent, last_ent;
    item_ch.valid        = 1'b0;
    item_ch.kind         = KIND_LOAD;
    item_ch.table_select = TABLE_MOD2;
    item_ch.block_number = '0;
    item_ch.entry_number = '0;
    item_ch.half_select  = 1'b0;
    item_ch.table_word   = '0;
    item_ch.input_index  = '0;
    last_ent = 0;
    for (int b = 0; b < BLOCK_COUNT; b++)
      for (int e = 0; e < ENTRIES; e++)
        loaded_mask[b][e] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Preload: the first entry of every block all zeros, the last all ones,
    // and one random entry with random words.
    for (int b = 0; b < BLOCK_COUNT; b++) begin
      for (int s = 0; s < 3; s++)
        for (int h = 0; h < 2; h++) begin
          send_load(2'(s), b, 0, 1'(h), '0);
          send_load(2'(s), b, ENTRIES - 1, 1'(h), '1);
        end
      fill_entry(b, $urandom_range(1, ENTRIES - 2));
    end

    // Loads to the unknown table must be dropped; no block lies beyond the cache.
    send_load(TABLE_NONE, 0, 0, 1'b0, '1);
    send_load(TABLE_NONE, 0, ENTRIES - 1, 1'b1, '0);
    for (int b = BLOCK_COUNT; b < 16; b++)
      send_load(TABLE_MOD2, b, 0, 1'b0, '1);

    // One vector mixing the all-ones and all-zeros entries with a random one.
    for (int i = 0; i < BLOCK_COUNT; i++) begin
      if (i == BLOCK_COUNT / 2)
        send_index(pick_index());
      else
        send_index((i % 2 == 0) ? ENTRIES - 1 : 0);
    end

    // Random traffic: mostly index beats, with whole-entry refills, single-word
    // overwrites and some beats aimed at the unknown table.
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_item(KIND_LOAD, TABLE_NONE, 4'($urandom), 8'($urandom), 1'($urandom),
                  rand_word(), 8'($urandom));
      end else if (r < 26) begin
        blk = ($urandom_range(0, 1) == 0) ? vec_pos : $urandom_range(0, BLOCK_COUNT - 1);
        ent = $urandom_range(0, ENTRIES - 1);
        fill_entry(blk, ent);
        // Read straight after the write to chase a read-after-write hazard.
        if (blk == vec_pos && $urandom_range(0, 1) == 0) begin
          last_ent = ent;
          send_index(ent);
        end
      end else if (r < 36) begin
        // Overwrite the entry just read, or any word at all.
        if ($urandom_range(0, 1) == 0)
          blk = (vec_pos + BLOCK_COUNT - 1) % BLOCK_COUNT;
        else
          blk = $urandom_range(0, BLOCK_COUNT - 1);
        ent = (blk != vec_pos && $urandom_range(0, 1) == 0) ? last_ent
                                                            : $urandom_range(0, ENTRIES - 1);
        send_load(2'($urandom_range(0, 2)), blk, ent, 1'($urandom), rand_word());
      end else begin
        last_ent = pick_index();
        send_index(last_ent);
      end
    end

    // Finish the vector in progress so that its sum is checked too.
    while (vec_pos != 0)
      send_index(pick_index());
    @(negedge clk);
    item_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== cached_inner_product_mod2_mod3.f =====
+incdir+rtl/core
rtl/core/cipm_pkg.sv
rtl/core/cipm_if.sv
rtl/core/cipm_queue.sv
rtl/core/cipm_front.sv
rtl/core/cipm_back.sv
rtl/core/cached_inner_product_mod2_mod3.sv
rtl/core/cipm_checker.sv
bench/cipm_checker.sv
bench/tb.sv
